// File: design/bbe_pkg.sv
// shared types and constants for the bernstein basis evaluator
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package bbe_pkg;

    localparam int MAX_TERMS = 16;
    localparam int ROW_DEPTH = 16;
    localparam int TERM_CAP  = (MAX_TERMS < ROW_DEPTH) ? MAX_TERMS : ROW_DEPTH;

    localparam int VAL_W  = 17;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int PROD_W = 2 * VAL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int FRAC_W = 16;

    localparam logic [VAL_W-1:0]  ONE_Q16   = VAL_W'(65536);
    localparam logic [VAL_W-1:0]  ZERO_Q16  = '0;
    localparam logic [ACC_W-1:0]  HALF_Q16  = ACC_W'(32768);
    localparam logic [CNT_W-1:0]  TERMS_RST = CNT_W'(4);
    localparam logic [CNT_W-1:0]  TERMS_CAP = CNT_W'(TERM_CAP);

    typedef struct packed {
        logic [VAL_W-1:0] sample;
        logic [IDX_W-1:0] last_idx;
    } item_t;

endpackage
`default_nettype wire

// File: design/bbe_front.sv
// front end: term count register, sample clamp and item build
// depends on bbe_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbe_front (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     cfg_wr_en,
    input  wire [bbe_pkg::CNT_W-1:0] cfg_wr_data,
    input  wire [bbe_pkg::VAL_W-1:0] sample,
    output bbe_pkg::item_t           item
);
    import bbe_pkg::*;

    logic [CNT_W-1:0] terms_reg;
    logic [CNT_W-1:0] terms_next;
    logic [CNT_W-1:0] eff_terms;

    always_comb
    begin
        terms_next = cfg_wr_en ? cfg_wr_data : terms_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg <= TERMS_RST;
        end
        else
        begin
            terms_reg <= terms_next;
        end
    end

    // zero acts as one, large counts saturate
    always_comb
    begin
        priority if (terms_reg == '0)
        begin
            eff_terms = CNT_W'(1);
        end
        else if (terms_reg > TERMS_CAP)
        begin
            eff_terms = TERMS_CAP;
        end
        else
        begin
            eff_terms = terms_reg;
        end
        item.sample   = (sample > ONE_Q16) ? ONE_Q16 : sample;
        item.last_idx = IDX_W'(eff_terms - CNT_W'(1));
    end

endmodule
`default_nettype wire

// File: design/bbe_queue.sv
// two entry queue between front end and evaluator
// depends on bbe_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbe_queue (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push,
    input  bbe_pkg::item_t push_item,
    input  wire            pop,
    output logic           full,
    output logic           not_empty,
    output bbe_pkg::item_t head
);
    import bbe_pkg::*;

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        not_empty   = (count_reg != 2'd0);
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

// File: design/bbe_back.sv
// evaluator: triangle recurrence on a row memory with one shared mix unit
// depends on bbe_pkg
`timescale 1ns / 1ps
`default_nettype none
module bbe_back (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      q_not_empty,
    input  bbe_pkg::item_t            q_head,
    output logic                     q_pop,
    output logic                     result_valid,
    output logic [bbe_pkg::IDX_W-1:0] basis_index,
    output logic [bbe_pkg::VAL_W-1:0] basis_value,
    output logic                     last_of_run
);
    import bbe_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_RD   = 5'b00010,
        ST_MUL  = 5'b00100,
        ST_WR   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t             state_reg, state_next;
    logic [VAL_W-1:0]   y_reg, y_next;
    logic [VAL_W-1:0]   omy_reg, omy_next;
    logic [IDX_W-1:0]   last_reg, last_next;
    logic [IDX_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [VAL_W-1:0]   prev_reg, prev_next;
    logic [PROD_W-1:0]  hi_prod_reg, hi_prod_next;
    logic [PROD_W-1:0]  lo_prod_reg, lo_prod_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]   pend_idx_reg, pend_idx_next;
    logic               pend_last_reg, pend_last_next;

    logic [VAL_W-1:0]   row_mem [ROW_DEPTH];
    logic [VAL_W-1:0]   rd_data_reg;
    logic               rd_en;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [VAL_W-1:0]   wr_data;

    logic [VAL_W-1:0]   old_j;
    logic [ACC_W-1:0]   acc;
    logic [ACC_W-FRAC_W-1:0] acc_q;
    logic [VAL_W-1:0]   mixed;

    always_comb
    begin
        old_j = (j_reg == k_reg) ? ZERO_Q16 : rd_data_reg;
        acc   = {1'b0, hi_prod_reg} + {1'b0, lo_prod_reg} + HALF_Q16;
        acc_q = acc[ACC_W-1:FRAC_W];
        mixed = (acc_q > {2'b00, ONE_Q16}) ? ONE_Q16 : acc_q[VAL_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        y_next          = y_reg;
        omy_next        = omy_reg;
        last_next       = last_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        prev_next       = prev_reg;
        hi_prod_next    = hi_prod_reg;
        lo_prod_next    = lo_prod_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = pend_idx_reg;
        pend_last_next  = pend_last_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = j_reg;
        wr_data         = mixed;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop     = 1'b1;
                    y_next    = q_head.sample;
                    omy_next  = ONE_Q16 - q_head.sample;
                    last_next = q_head.last_idx;
                    wr_en     = 1'b1;
                    wr_addr   = '0;
                    wr_data   = ONE_Q16;
                    k_next    = IDX_W'(1);
                    j_next    = '0;
                    prev_next = ZERO_Q16;
                    state_next = (q_head.last_idx == '0) ? ST_OUT : ST_RD;
                end
            end
            ST_RD:
            begin
                rd_en      = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                hi_prod_next = PROD_W'(omy_reg) * PROD_W'(old_j);
                lo_prod_next = PROD_W'(y_reg) * PROD_W'(prev_reg);
                prev_next    = old_j;
                state_next   = ST_WR;
            end
            ST_WR:
            begin
                wr_en = 1'b1;
                if (j_reg == k_reg)
                begin
                    j_next    = '0;
                    prev_next = ZERO_Q16;
                    if (k_reg == last_reg)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        k_next     = k_reg + IDX_W'(1);
                        state_next = ST_RD;
                    end
                end
                else
                begin
                    j_next     = j_reg + IDX_W'(1);
                    state_next = ST_RD;
                end
            end
            ST_OUT:
            begin
                rd_en           = 1'b1;
                pend_valid_next = 1'b1;
                pend_idx_next   = j_reg;
                pend_last_next  = (j_reg == last_reg);
                j_next          = j_reg + IDX_W'(1);
                if (j_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg         <= y_next;
        omy_reg       <= omy_next;
        last_reg      <= last_next;
        k_reg         <= k_next;
        j_reg         <= j_next;
        prev_reg      <= prev_next;
        hi_prod_reg   <= hi_prod_next;
        lo_prod_reg   <= lo_prod_next;
        pend_idx_reg  <= pend_idx_next;
        pend_last_reg <= pend_last_next;
    end

    // row memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= row_mem[j_reg];
        end
    end

    always_comb
    begin
        result_valid = pend_valid_reg;
        basis_index  = pend_idx_reg;
        basis_value  = rd_data_reg;
        last_of_run  = pend_last_reg;
    end

endmodule
`default_nettype wire

// File: design/bernstein_basis_eval.sv
// top level of the bernstein basis evaluator
// depends on bbe_pkg, bbe_front, bbe_queue, bbe_back
`timescale 1ns / 1ps
`default_nettype none
// A sample beat is taken when start is high and busy is low; samples above
// 65536 are clamped to 1.0. Each sample yields num_terms result beats (zero
// counts as one, above 16 as 16), index 0 first, each shown for one cycle
// with result_valid and last_of_run on the final one. The receiver cannot
// stall: results must be taken as they come. Up to two samples wait in a
// queue; busy is high only when it is full. The evaluator uses one mix unit
// and a row memory; each recurrence element passes through a read, a
// multiply and a write state in turn, and the results are then read out.
// num_terms is sampled when a sample beat is taken.
module bernstein_basis_eval (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_wr_en,
    input  wire  [4:0]  cfg_wr_data,
    input  wire         start,
    output logic        busy,
    input  wire  [16:0] sample,
    output logic        result_valid,
    output logic [3:0]  basis_index,
    output logic [16:0] basis_value,
    output logic        last_of_run
);
    import bbe_pkg::*;

    item_t front_item;
    item_t q_head;
    logic  q_full;
    logic  q_not_empty;
    logic  q_pop;
    logic  accept;

    assign busy   = q_full;
    assign accept = start & ~q_full;

    bbe_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .sample      (sample),
        .item        (front_item)
    );

    bbe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_item (front_item),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bbe_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_head       (q_head),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .basis_index  (basis_index),
        .basis_value  (basis_value),
        .last_of_run  (last_of_run)
    );

endmodule
`default_nettype wire
